// ----- design/neighbor_address_cache_aging_macros.svh -----
// Assertion macros for the neighbor address cache.
// Expects clk and arst_n in the scope of each use; compiled out under SYNTHESIS.
`ifndef NEIGHBOR_ADDRESS_CACHE_AGING_MACROS_SVH
`define NEIGHBOR_ADDRESS_CACHE_AGING_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NAC_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("neighbor cache assertion failed");
// next-cycle implication
`define NAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("neighbor cache assertion failed");
`else
`define NAC_ASSERT(lbl, ante, cons)
`define NAC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/nac_pkg.sv -----
// Shared types and constants for the neighbor address cache.
// No dependencies; used by every module of the block.
package nac_pkg;

	// default sizes
	localparam int DEF_IP_ENTRIES  = 64;
	localparam int DEF_MAC_ENTRIES = 64;
	localparam int DEF_IF_COUNT    = 16;

	// register reset value
	localparam logic [39:0] MAX_AGE_RESET = 40'd3600000000;

	// opcodes
	localparam logic [1:0] OP_LEARN     = 2'd0;
	localparam logic [1:0] OP_QUERY_IP  = 2'd1;
	localparam logic [1:0] OP_QUERY_MAC = 2'd2;
	localparam logic [1:0] OP_SWEEP     = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_NEW        = 3'd0;
	localparam logic [2:0] STAT_UPDATED    = 3'd1;
	localparam logic [2:0] STAT_KEPT       = 3'd2;
	localparam logic [2:0] STAT_HIT        = 3'd3;
	localparam logic [2:0] STAT_MISS       = 3'd4;
	localparam logic [2:0] STAT_NOT_STATIC = 3'd5;
	localparam logic [2:0] STAT_FULL       = 3'd6;
	localparam logic [2:0] STAT_SWEEP      = 3'd7;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] ip_high;
		logic [63:0] ip_low;
		logic        ip_is_v6;
		logic [47:0] mac_addr;
		logic [3:0]  interface_id;
		logic        static_flag;
		logic [63:0] now_us;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        hit;
		logic [3:0]  found_interface;
		logic [47:0] found_mac;
		logic [6:0]  removed_count;
	} rsp_t;

	// one word of the IP table
	typedef struct packed {
		logic        valid;
		logic        is_v6;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [47:0] mac;
		logic [3:0]  iface;
		logic        is_static;
		logic [63:0] learn_time;
	} ip_entry_t;

	// one word of the MAC table
	typedef struct packed {
		logic        valid;
		logic [47:0] addr;
		logic [3:0]  iface;
	} mac_entry_t;

	// per-entry outcome of the compare unit
	typedef struct packed {
		logic ip_hit;
		logic ip_free;
		logic mac_hit;
		logic mac_free;
		logic aged;
	} flags_t;

endpackage

// ----- design/nac_ram.sv -----
// Simple dual-port table memory: one write port, one registered read port.
// Depends on nac_pkg for the default word type.
module nac_ram #(
	parameter int DEPTH = nac_pkg::DEF_IP_ENTRIES,
	parameter int WIDTH = $bits(nac_pkg::ip_entry_t),
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- design/nac_match.sv -----
// Shared compare unit: checks one IP word and one MAC word against the item.
// Depends on nac_pkg for the entry and flag types.
module nac_match (
	input  logic                  v6,
	input  logic [63:0]           key_high,
	input  logic [63:0]           key_low,
	input  logic [47:0]           mac,
	input  logic [63:0]           now_us,
	input  logic [39:0]           max_age,
	input  nac_pkg::ip_entry_t    ip_rd,
	input  nac_pkg::mac_entry_t   mac_rd,
	output nac_pkg::flags_t       flags
);

	logic [63:0] age;

	// age wraps modulo 2^64
	assign age = now_us - ip_rd.learn_time;

	always_comb begin
		flags.ip_hit   = ip_rd.valid && (ip_rd.is_v6 == v6) &&
			(ip_rd.key_high == key_high) && (ip_rd.key_low == key_low);
		flags.ip_free  = !ip_rd.valid;
		flags.mac_hit  = mac_rd.valid && (mac_rd.addr == mac);
		flags.mac_free = !mac_rd.valid;
		flags.aged     = ip_rd.valid && !ip_rd.is_static && (age >= {24'd0, max_age});
	end

endmodule

// ----- design/neighbor_address_cache_aging.sv -----
// Neighbor address cache top level: sequencer, APB register, table memories.
// Depends on nac_pkg, nac_ram, nac_match and the assertion macro header.
//
// Usage:
//   Requests enter on req (req_valid/req_ready), one beat per operation:
//   learn, query by IP, query by MAC or age sweep. Each request yields one
//   response beat on rsp (rsp_valid/rsp_ready).
//   After reset a clearing pass walks both tables, one entry a cycle, and
//   invalidates every entry; req_ready stays low meanwhile.
//   max_age_us is reset to 3600000000 and is written over APB at byte address 0
//   (64-bit data); the user must do so while the block is idle, which it does not enforce.
//   Each request walks both tables through the shared compare unit, one
//   word of each per cycle from the memory read ports, then passes the
//   DRAIN, WRITE and RESP states; the response is registered in RESP and
//   the next request is taken only once the sequencer is back in IDLE.
//   The response sits in an output register; if the receiver stalls, the
//   next request is still accepted and scanned, and its response waits
//   until the register is free.
module neighbor_address_cache_aging #(
	parameter int IP_ENTRIES  = nac_pkg::DEF_IP_ENTRIES,
	parameter int MAC_ENTRIES = nac_pkg::DEF_MAC_ENTRIES,
	parameter int IF_COUNT    = nac_pkg::DEF_IF_COUNT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  nac_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output nac_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	`include "neighbor_address_cache_aging_macros.svh"

	localparam int IpAw    = $clog2(IP_ENTRIES);
	localparam int MacAw   = $clog2(MAC_ENTRIES);
	localparam int ScanLen = (IP_ENTRIES > MAC_ENTRIES) ? IP_ENTRIES : MAC_ENTRIES;
	localparam int CntW    = $clog2(ScanLen + 1);
	localparam int IfMax   = (IF_COUNT > 16) ? 15 : IF_COUNT - 1;
	localparam logic [3:0]      IfMaxV  = 4'(IfMax);
	localparam logic [CntW-1:0] LastIdx = CntW'(ScanLen - 1);
	localparam logic [CntW-1:0] IpLen   = CntW'(IP_ENTRIES);
	localparam logic [CntW-1:0] MacLen  = CntW'(MAC_ENTRIES);

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]           state_q;
	logic [CntW-1:0]      cnt_q;
	logic                 rd_vld_s1;
	logic [CntW-1:0]      idx_s1;
	logic [39:0]          max_age_q;
	nac_pkg::req_t        req_q;
	nac_pkg::rsp_t        rsp_q;
	nac_pkg::rsp_t        res;
	logic                 rsp_valid_q;

	// scan results
	logic                 ip_hit_q;
	logic [IpAw-1:0]      ip_idx_q;
	logic                 ip_static_q;
	logic [47:0]          ip_mac_q;
	logic [3:0]           ip_ifc_q;
	logic                 ip_free_q;
	logic [IpAw-1:0]      ip_free_idx_q;
	logic                 mac_hit_q;
	logic [3:0]           mac_ifc_q;
	logic                 mac_free_q;
	logic [MacAw-1:0]     mac_free_idx_q;
	logic [6:0]           removed_q;

	// memory ports
	logic                 ip_we;
	logic [IpAw-1:0]      ip_waddr;
	nac_pkg::ip_entry_t   ip_wdata;
	nac_pkg::ip_entry_t   ip_rd;
	logic                 mac_we;
	logic [MacAw-1:0]     mac_waddr;
	nac_pkg::mac_entry_t  mac_wdata;
	nac_pkg::mac_entry_t  mac_rd;
	nac_pkg::flags_t      flags;

	logic                 accept;
	logic                 ip_in_s1;
	logic                 mac_in_s1;
	logic                 sweep_wr;
	logic                 learn_ip_wr;
	logic                 learn_mac_wr;
	logic                 rsp_load;
	nac_pkg::ip_entry_t   new_entry;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign ip_in_s1  = (idx_s1 < IpLen);
	assign mac_in_s1 = (idx_s1 < MacLen);
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[3] == 1'b0) ? {24'd0, max_age_q} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= nac_pkg::MAX_AGE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[3] == 1'b0)) begin
			max_age_q <= pwdata[39:0];
		end
	end

	// table memories
	nac_ram #(.DEPTH(IP_ENTRIES), .WIDTH($bits(nac_pkg::ip_entry_t))) u_ip_ram (
		.clk   (clk),
		.we    (ip_we),
		.waddr (ip_waddr),
		.wdata (ip_wdata),
		.raddr (cnt_q[IpAw-1:0]),
		.rdata (ip_rd)
	);

	nac_ram #(.DEPTH(MAC_ENTRIES), .WIDTH($bits(nac_pkg::mac_entry_t))) u_mac_ram (
		.clk   (clk),
		.we    (mac_we),
		.waddr (mac_waddr),
		.wdata (mac_wdata),
		.raddr (cnt_q[MacAw-1:0]),
		.rdata (mac_rd)
	);

	// shared compare unit
	nac_match u_match (
		.v6       (req_q.ip_is_v6),
		.key_high (req_q.ip_high),
		.key_low  (req_q.ip_low),
		.mac      (req_q.mac_addr),
		.now_us   (req_q.now_us),
		.max_age  (max_age_q),
		.ip_rd    (ip_rd),
		.mac_rd   (mac_rd),
		.flags    (flags)
	);

	// write selection
	always_comb begin
		new_entry            = '0;
		new_entry.valid      = 1'b1;
		new_entry.is_v6      = req_q.ip_is_v6;
		new_entry.key_high   = req_q.ip_high;
		new_entry.key_low    = req_q.ip_low;
		new_entry.mac        = req_q.mac_addr;
		new_entry.iface      = req_q.interface_id;
		new_entry.is_static  = req_q.static_flag;
		new_entry.learn_time = req_q.now_us;

		sweep_wr     = rd_vld_s1 && ip_in_s1 && (req_q.opcode == nac_pkg::OP_SWEEP) &&
			flags.aged;
		learn_ip_wr  = (state_q == S_WRITE) && (req_q.opcode == nac_pkg::OP_LEARN) &&
			!(ip_hit_q && ip_static_q) && (ip_hit_q || ip_free_q);
		learn_mac_wr = (state_q == S_WRITE) && (req_q.opcode == nac_pkg::OP_LEARN) &&
			!mac_hit_q && mac_free_q;

		ip_we    = 1'b0;
		ip_waddr = cnt_q[IpAw-1:0];
		ip_wdata = '0;
		if (state_q == S_CLEAR) begin
			ip_we = (cnt_q < IpLen);
		end else if (sweep_wr) begin
			ip_we          = 1'b1;
			ip_waddr       = idx_s1[IpAw-1:0];
			ip_wdata       = ip_rd;
			ip_wdata.valid = 1'b0;
		end else if (learn_ip_wr) begin
			ip_we    = 1'b1;
			ip_waddr = ip_hit_q ? ip_idx_q : ip_free_idx_q;
			ip_wdata = new_entry;
		end

		mac_we    = 1'b0;
		mac_waddr = cnt_q[MacAw-1:0];
		mac_wdata = '0;
		if (state_q == S_CLEAR) begin
			mac_we = (cnt_q < MacLen);
		end else if (learn_mac_wr) begin
			mac_we          = 1'b1;
			mac_waddr       = mac_free_idx_q;
			mac_wdata.valid = 1'b1;
			mac_wdata.addr  = req_q.mac_addr;
			mac_wdata.iface = req_q.interface_id;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastIdx) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastIdx) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_WRITE;
				S_WRITE: state_q <= S_RESP;
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// read index follows the read data
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	// item register: key normalized, interface clamped
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			if (!req.ip_is_v6) begin
				req_q.ip_high <= 64'd0;
				req_q.ip_low  <= {32'd0, req.ip_low[31:0]};
			end
			if (req.interface_id > IfMaxV) begin
				req_q.interface_id <= IfMaxV;
			end
		end
	end

	// collect scan results, first match and lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_hit_q   <= 1'b0;
			ip_free_q  <= 1'b0;
			mac_hit_q  <= 1'b0;
			mac_free_q <= 1'b0;
			removed_q  <= '0;
		end else if (accept) begin
			ip_hit_q   <= 1'b0;
			ip_free_q  <= 1'b0;
			mac_hit_q  <= 1'b0;
			mac_free_q <= 1'b0;
			removed_q  <= '0;
		end else if (rd_vld_s1) begin
			if (ip_in_s1 && flags.ip_hit && !ip_hit_q) begin
				ip_hit_q <= 1'b1;
			end
			if (ip_in_s1 && flags.ip_free && !ip_free_q) begin
				ip_free_q <= 1'b1;
			end
			if (mac_in_s1 && flags.mac_hit && !mac_hit_q) begin
				mac_hit_q <= 1'b1;
			end
			if (mac_in_s1 && flags.mac_free && !mac_free_q) begin
				mac_free_q <= 1'b1;
			end
			if (sweep_wr) begin
				removed_q <= removed_q + 1'b1;
			end
		end
	end

	// payload of the captured entries
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (ip_in_s1 && flags.ip_hit && !ip_hit_q) begin
				ip_idx_q    <= idx_s1[IpAw-1:0];
				ip_static_q <= ip_rd.is_static;
				ip_mac_q    <= ip_rd.mac;
				ip_ifc_q    <= ip_rd.iface;
			end
			if (ip_in_s1 && flags.ip_free && !ip_free_q) begin
				ip_free_idx_q <= idx_s1[IpAw-1:0];
			end
			if (mac_in_s1 && flags.mac_hit && !mac_hit_q) begin
				mac_ifc_q <= mac_rd.iface;
			end
			if (mac_in_s1 && flags.mac_free && !mac_free_q) begin
				mac_free_idx_q <= idx_s1[MacAw-1:0];
			end
		end
	end

	// result from the scan outcome
	always_comb begin
		res        = '0;
		res.status = nac_pkg::STAT_MISS;
		unique case (req_q.opcode)
			nac_pkg::OP_LEARN: begin
				if (ip_hit_q && ip_static_q) begin
					res.status = nac_pkg::STAT_KEPT;
				end else if (ip_hit_q) begin
					res.status = nac_pkg::STAT_UPDATED;
				end else if (ip_free_q) begin
					res.status = nac_pkg::STAT_NEW;
				end else begin
					res.status = nac_pkg::STAT_FULL;
				end
				if (!mac_hit_q && !mac_free_q) begin
					res.status = nac_pkg::STAT_FULL;
				end
			end
			nac_pkg::OP_QUERY_IP: begin
				if (!ip_hit_q) begin
					res.status = nac_pkg::STAT_MISS;
				end else if (req_q.static_flag && !ip_static_q) begin
					res.status = nac_pkg::STAT_NOT_STATIC;
				end else begin
					res.status          = nac_pkg::STAT_HIT;
					res.hit             = 1'b1;
					res.found_interface = ip_ifc_q;
					res.found_mac       = ip_mac_q;
				end
			end
			nac_pkg::OP_QUERY_MAC: begin
				if (mac_hit_q) begin
					res.status          = nac_pkg::STAT_HIT;
					res.hit             = 1'b1;
					res.found_interface = mac_ifc_q;
				end
			end
			nac_pkg::OP_SWEEP: begin
				res.status        = nac_pkg::STAT_SWEEP;
				res.removed_count = removed_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`NAC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	`NAC_ASSERT(a_hit_means_hit_status, rsp_valid && rsp.hit, rsp.status == nac_pkg::STAT_HIT)
	`NAC_ASSERT(a_removed_only_sweep, rsp_valid && (rsp.status != nac_pkg::STAT_SWEEP), rsp.removed_count == 7'd0)

endmodule
